// File: design/vne_pkg.sv
`default_nettype none
package vne_pkg;

  localparam int unsigned ACC_W  = 47;
  localparam int unsigned NORM_W = 32;
  localparam int unsigned ROOT_W = 24;

  localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [NORM_W-1:0] NORM_MAX = {1'b1, {(NORM_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]  ROOT_BIT_INIT = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic [ACC_W-1:0] acc_t;

  typedef struct packed {
    acc_t acc;
    logic sat;
  } step_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

  typedef enum logic [1:0] {
    ST_ACC  = 2'b01,
    ST_ROOT = 2'b10
  } state_e;

endpackage
`default_nettype wire

// File: design/vne_elem_if.sv
`default_nettype none
interface vne_elem_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] element;
  logic                           last;

  modport source (output valid, output element, output last, input ready);
  modport sink   (input valid, input element, input last, output ready);
endinterface
`default_nettype wire

// File: design/vne_norm_if.sv
`default_nettype none
interface vne_norm_if;
  logic        valid;
  logic        ready;
  logic [31:0] norm;
  logic        overflow;

  modport source (output valid, output norm, output overflow, input ready);
  modport sink   (input valid, input norm, input overflow, output ready);
endinterface
`default_nettype wire

// File: design/vne_accum.sv
`default_nettype none
module vne_accum
  import vne_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 65536,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic [SAMPLE_WIDTH-1:0] element_i,
  input  wire logic                    last_i,
  input  wire logic                    mode_i,
  output step_t                        step_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned TW    = 2 * SAMPLE_WIDTH;
  localparam int unsigned SUM_W = ((TW > ACC_W) ? TW : ACC_W) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

  acc_t             acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             sat_q;

  logic [SAMPLE_WIDTH-1:0] mag;
  logic [TW-1:0]           term;
  logic [SUM_W-1:0]        sum;
  logic                    full;
  logic                    sat_d;

  always_comb begin
    mag  = element_i[SAMPLE_WIDTH-1] ? (~element_i + 1'b1) : element_i;
    term = mode_i ? (TW'(mag) * TW'(mag)) : TW'(mag);
    sum  = SUM_W'(acc_q) + SUM_W'(term);
    full = (cnt_q == CNT_MAX);
    acc_d = acc_q;
    cnt_d = cnt_q;
    sat_d = sat_q;
    if (full) begin
      sat_d = 1'b1;
    end else begin
      cnt_d = cnt_q + 1'b1;
      if (sum > SUM_W'(ACC_MAX)) begin
        acc_d = ACC_MAX;
        sat_d = 1'b1;
      end else begin
        acc_d = sum[ACC_W-1:0];
      end
    end
  end

  assign step_o = '{acc: acc_d, sat: sat_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      sat_q <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        acc_q <= '0;
        cnt_q <= '0;
        sat_q <= 1'b0;
      end else begin
        acc_q <= acc_d;
        cnt_q <= cnt_d;
        sat_q <= sat_d;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/vne_root.sv
`default_nettype none
module vne_root
  import vne_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  acc_t                   operand_i,
  output root_stat_t             stat_o,
  output logic [ROOT_W-1:0]      root_o
);

  acc_t v_q, v_d;
  acc_t root_q, root_d;
  acc_t bit_q, bit_d;
  logic done_q;
  acc_t trial;

  // one result bit per cycle, restoring
  always_comb begin
    trial  = root_q + bit_q;
    v_d    = v_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (start_i) begin
      v_d    = operand_i;
      root_d = '0;
      bit_d  = ROOT_BIT_INIT;
    end else if (bit_q != '0) begin
      bit_d = bit_q >> 2;
      if (v_q >= trial) begin
        v_d    = v_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    root_q <= root_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      bit_q  <= bit_d;
      done_q <= !start_i && (bit_q != '0) && (bit_d == '0);
    end
  end

  assign stat_o = '{busy: (bit_q != '0), done: done_q};
  assign root_o = root_q[ROOT_W-1:0];

endmodule
`default_nettype wire

// File: design/vector_norm_engine_unit.sv
`default_nettype none
// Streaming vector norm. Elements (signed Q1.15) arrive on elem_i, one beat per
// cycle, with last marking the end of a vector. norm_mode selects the sum of
// absolute values (0) or the floor square root of the sum of squares (1, reset
// value). Beats are taken every cycle while no square root is in progress and no
// result waits unaccepted in the output register. A last beat in L1 mode yields its
// result on norm_o in the next cycle; in L2 mode the restoring square-root unit
// resolves one root bit per cycle, so the input stalls after the last beat until
// the 24-bit root is resolved and loaded into the output register. More
// than MAX_ELEMENTS elements, or a sum past 2^47-1, saturates the result and sets
// overflow. Write norm_mode only while the block is idle.
module vector_norm_engine_unit
  import vne_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 65536,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   norm_mode_we_i,
  input  wire logic   norm_mode_i,
  vne_elem_if.sink    elem_i,
  vne_norm_if.source  norm_o
);

  state_e state_q, state_d;
  logic   mode_q;
  logic   accept;
  logic   out_free;
  step_t  step;
  root_stat_t root_stat;
  logic [ROOT_W-1:0] root;
  logic   root_start;
  acc_t   root_operand;

  logic              out_valid_q;
  logic [NORM_W-1:0] out_norm_q;
  logic              out_ovf_q;
  logic              ovf_pend_q;
  logic [NORM_W-1:0] l1_norm;

  assign out_free     = !out_valid_q || norm_o.ready;
  assign elem_i.ready = (state_q == ST_ACC) && out_free;
  assign accept       = elem_i.valid && elem_i.ready;
  assign root_start   = accept && elem_i.last && mode_q;
  assign root_operand = step.sat ? ACC_MAX : step.acc;

  assign l1_norm = (step.sat || (step.acc > ACC_W'(NORM_MAX))) ? NORM_MAX
                                                               : step.acc[NORM_W-1:0];

  vne_accum #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .element_i (elem_i.element),
    .last_i    (elem_i.last),
    .mode_i    (mode_q),
    .step_o    (step)
  );

  vne_root u_root (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (root_start),
    .operand_i (root_operand),
    .stat_o    (root_stat),
    .root_o    (root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC:  if (root_start) state_d = ST_ROOT;
      ST_ROOT: if (root_stat.done && !root_stat.busy) state_d = ST_ACC;
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      mode_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (norm_mode_we_i) begin
        mode_q <= norm_mode_i;
      end
      if (accept && elem_i.last && !mode_q) begin
        out_valid_q <= 1'b1;
      end else if (state_q == ST_ROOT && root_stat.done) begin
        out_valid_q <= 1'b1;
      end else if (norm_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && elem_i.last) begin
      ovf_pend_q <= step.sat;
      if (!mode_q) begin
        out_norm_q <= l1_norm;
        out_ovf_q  <= step.sat;
      end
    end else if (state_q == ST_ROOT && root_stat.done) begin
      out_norm_q <= NORM_W'(root);
      out_ovf_q  <= ovf_pend_q;
    end
  end

  assign norm_o.valid    = out_valid_q;
  assign norm_o.norm     = out_norm_q;
  assign norm_o.overflow = out_ovf_q;

endmodule
`default_nettype wire

// File: tb/tb_vector_norm_engine_unit.sv
`timescale 1ns / 100ps
module tb_vector_norm_engine_unit;
  import vne_pkg::*;

  localparam int unsigned MAX_ELEMENTS = 65536;
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned IDLE_PCT     = 32;

  localparam logic MODE_L1 = 1'b0;
  localparam logic MODE_L2 = 1'b1;

  typedef struct packed {
    logic [31:0] norm;
    logic        overflow;
  } norm_result_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] element;
    logic        last;
    logic        typed;
    logic [31:0] norm;
    logic        overflow;
  } norm_row_t;

  localparam int NUM_ROWS = 22;
  localparam norm_row_t ROWS [NUM_ROWS] = '{
    '{MODE_L2, 16'h0000, 1'b1, 1'b1, 32'd0,     1'b0},
    '{MODE_L2, 16'h7fff, 1'b1, 1'b1, 32'd32767, 1'b0},
    '{MODE_L2, 16'h8000, 1'b1, 1'b1, 32'd32768, 1'b0},
    '{MODE_L2, 16'h0001, 1'b1, 1'b1, 32'd1,     1'b0},
    '{MODE_L2, 16'hffff, 1'b1, 1'b1, 32'd1,     1'b0},
    '{MODE_L2, 16'h0003, 1'b0, 1'b0, 32'd0,     1'b0},
    '{MODE_L2, 16'h0004, 1'b1, 1'b1, 32'd5,     1'b0},
    '{MODE_L2, 16'h7fff, 1'b0, 1'b0, 32'd0,     1'b0},
    '{MODE_L2, 16'h8000, 1'b0, 1'b0, 32'd0,     1'b0},
    '{MODE_L2, 16'h3039, 1'b1, 1'b0, 32'd0,     1'b0},
    '{MODE_L1, 16'h0000, 1'b1, 1'b1, 32'd0,     1'b0},
    '{MODE_L1, 16'h7fff, 1'b1, 1'b1, 32'd32767, 1'b0},
    '{MODE_L1, 16'h8000, 1'b1, 1'b1, 32'd32768, 1'b0},
    '{MODE_L1, 16'hffff, 1'b0, 1'b0, 32'd0,     1'b0},
    '{MODE_L1, 16'h8000, 1'b0, 1'b0, 32'd0,     1'b0},
    '{MODE_L1, 16'h7fff, 1'b1, 1'b0, 32'd0,     1'b0},
    // mode flips in the middle of a vector
    '{MODE_L1, 16'h03e8, 1'b0, 1'b0, 32'd0,     1'b0},
    '{MODE_L2, 16'hf830, 1'b0, 1'b0, 32'd0,     1'b0},
    '{MODE_L2, 16'h012c, 1'b1, 1'b0, 32'd0,     1'b0},
    '{MODE_L2, 16'h0007, 1'b0, 1'b0, 32'd0,     1'b0},
    '{MODE_L1, 16'hfff7, 1'b1, 1'b0, 32'd0,     1'b0},
    '{MODE_L2, 16'h5a5a, 1'b1, 1'b0, 32'd0,     1'b0}
  };

  logic clk_i;
  logic rst_ni;
  logic norm_mode_we_i;
  logic norm_mode_i;

  logic        tag_typed;
  logic [31:0] tag_norm;
  logic        tag_overflow;

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned hold_reqs;
  int unsigned hold_seen;
  int unsigned sink_idle_pct;
  int unsigned src_idle_pct;
  logic        cur_mode;

  norm_result_t pending_norms [$];

  vne_elem_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) elem_bus ();
  vne_norm_if norm_bus ();

  vector_norm_engine_unit #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .norm_mode_we_i (norm_mode_we_i),
    .norm_mode_i    (norm_mode_i),
    .elem_i         (elem_bus.sink),
    .norm_o         (norm_bus.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // predictor state
  logic [ACC_W-1:0] sum_acc;
  logic [16:0]      elem_cnt;
  logic             sum_sat;
  logic             mode_shadow;

  function automatic logic [31:0] floor_root(input logic [ACC_W-1:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 23; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= {17'd0, v}) r = c;
    end
    return r[31:0];
  endfunction

  task automatic absorb_element(input logic [15:0] e, input logic lst);
    logic [16:0]      mag;
    logic [ACC_W-1:0] mag_w;
    logic [ACC_W-1:0] term;
    norm_result_t     res;
    mag   = e[15] ? 17'(17'h10000 - {1'b0, e}) : {1'b0, e};
    mag_w = ACC_W'(mag);
    term  = (mode_shadow == MODE_L2) ? mag_w * mag_w : mag_w;
    if (elem_cnt >= 17'(MAX_ELEMENTS)) begin
      sum_sat = 1'b1;
    end else begin
      elem_cnt = elem_cnt + 1'b1;
      if (term > ACC_MAX - sum_acc) begin
        sum_acc = ACC_MAX;
        sum_sat = 1'b1;
      end else begin
        sum_acc = sum_acc + term;
      end
    end
    if (lst) begin
      if (mode_shadow == MODE_L2) begin
        res.norm = floor_root(sum_sat ? ACC_MAX : sum_acc);
      end else if (sum_sat || sum_acc > ACC_W'(NORM_MAX)) begin
        res.norm = NORM_MAX;
      end else begin
        res.norm = sum_acc[31:0];
      end
      res.overflow = sum_sat;
      if (tag_typed) begin
        res.norm     = tag_norm;
        res.overflow = tag_overflow;
      end
      pending_norms.push_back(res);
      sum_acc  = '0;
      elem_cnt = '0;
      sum_sat  = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_acc     = '0;
      elem_cnt    = '0;
      sum_sat     = 1'b0;
      mode_shadow = MODE_L2;
    end else begin
      if (elem_bus.valid && elem_bus.ready) absorb_element(elem_bus.element, elem_bus.last);
      if (norm_mode_we_i) mode_shadow = norm_mode_i;
    end
  end

  always @(posedge clk_i) begin
    norm_result_t want;
    if (rst_ni && norm_bus.valid && norm_bus.ready) begin
      if (pending_norms.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat: norm=%0d overflow=%0b", norm_bus.norm, norm_bus.overflow);
        mismatches <= mismatches + 1;
      end else begin
        want = pending_norms.pop_front();
        if (want.norm !== norm_bus.norm || want.overflow !== norm_bus.overflow) begin
          if (mismatches < 10)
            $display("mismatch: expected norm=%0d overflow=%0b, got norm=%0d overflow=%0b",
                     want.norm, want.overflow, norm_bus.norm, norm_bus.overflow);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // result sink backpressure
  initial begin
    norm_bus.ready <= 1'b0;
    hold_seen = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        norm_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        norm_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(input logic [15:0] e, input logic lst, input logic typed,
                           input logic [31:0] nrm, input logic ovf);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      elem_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    elem_bus.valid   <= 1'b1;
    elem_bus.element <= e;
    elem_bus.last    <= lst;
    tag_typed        <= typed;
    tag_norm         <= nrm;
    tag_overflow     <= ovf;
    do @(posedge clk_i); while (!elem_bus.ready);
  endtask

  task automatic drain();
    elem_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_norms.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    drain();
    norm_mode_we_i <= 1'b1;
    norm_mode_i    <= m;
    @(posedge clk_i);
    norm_mode_we_i <= 1'b0;
    cur_mode = m;
  endtask

  task automatic send_run(input int unsigned n, input logic [15:0] e, input logic typed,
                          input logic [31:0] nrm, input logic ovf);
    for (int unsigned i = 0; i < n; i++) send_beat(e, i == n - 1, typed, nrm, ovf);
  endtask

  function automatic logic [15:0] rand_element();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_beat(rand_element(), i == len - 1, 1'b0, 0, 1'b0);
  endtask

  initial begin
    int unsigned items;
    int unsigned len;
    rst_ni           <= 1'b0;
    norm_mode_we_i   <= 1'b0;
    norm_mode_i      <= MODE_L2;
    elem_bus.valid   <= 1'b0;
    elem_bus.element <= '0;
    elem_bus.last    <= 1'b0;
    tag_typed        <= 1'b0;
    tag_norm         <= '0;
    tag_overflow     <= 1'b0;
    cycle_count      <= 0;
    mismatches       <= 0;
    hold_reqs        <= 0;
    sink_idle_pct    <= IDLE_PCT;
    src_idle_pct     = IDLE_PCT;
    cur_mode         = MODE_L2;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (ROWS[r].mode != cur_mode) set_mode(ROWS[r].mode);
      send_beat(ROWS[r].element, ROWS[r].last, ROWS[r].typed, ROWS[r].norm, ROWS[r].overflow);
    end

    // element bound: exactly full, then one past it
    set_mode(MODE_L1);
    send_run(MAX_ELEMENTS, 16'h8000, 1'b1, NORM_MAX, 1'b0);
    send_run(MAX_ELEMENTS + 1, 16'h8000, 1'b1, NORM_MAX, 1'b1);
    set_mode(MODE_L2);
    send_run(MAX_ELEMENTS + 1, 16'h8000, 1'b0, 0, 1'b0);

    // long sink hold-off while the source keeps pushing
    set_mode(MODE_L1);
    hold_reqs <= hold_reqs + 1;
    for (int v = 0; v < 20; v++) send_vector($urandom_range(1, 4));
    drain();

    for (int blk = 0; blk < 10; blk++) begin
      set_mode(blk < 2 ? logic'(blk) : logic'($urandom_range(1)));
      if (blk == 3) begin
        src_idle_pct = 0;
        sink_idle_pct <= 0;
      end else begin
        src_idle_pct = IDLE_PCT;
        sink_idle_pct <= IDLE_PCT;
      end
      items = 0;
      while (items < 150) begin
        len = ($urandom_range(15) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
        send_vector(len);
        items += len;
      end
    end

    drain();
    if (mismatches == 0 && pending_norms.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
